[hdl/scfk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfk_pkg
// Shared types and constants of the skeleton chain forward kinematics block.
// ----------------------------------------------------------------------------
package scfk_pkg;

  localparam int FRAC_BITS = 14;

  localparam int COMP_W  = 16;
  localparam int QUAT_W  = 4 * COMP_W;
  localparam int PROD_W  = 2 * COMP_W;
  localparam int DIR_W   = PROD_W + 2;
  localparam int LEN_W   = 16;
  localparam int TERM_W  = DIR_W + LEN_W + 1;
  localparam int SUM_W   = TERM_W + 2;
  localparam int COORD_W = 24;
  localparam int CHAIN_W = 3;
  localparam int NUM_LEN = 8;
  localparam int IDX_W   = $clog2(NUM_LEN);

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [LEN_W-1:0]        len_t;

  typedef enum logic [1:0] {
    AXIS_PX = 2'd0,
    AXIS_NX = 2'd1,
    AXIS_PY = 2'd2,
    AXIS_NY = 2'd3
  } axis_e;

  localparam logic [CHAIN_W-1:0] CHAIN_LEFT_WRIST  = 3'd0;
  localparam logic [CHAIN_W-1:0] CHAIN_RIGHT_WRIST = 3'd1;
  localparam logic [CHAIN_W-1:0] CHAIN_LEFT_ANKLE  = 3'd2;
  localparam logic [CHAIN_W-1:0] CHAIN_RIGHT_ANKLE = 3'd3;
  localparam logic [CHAIN_W-1:0] CHAIN_NECK        = 3'd4;

  localparam logic [IDX_W-1:0] IDX_NECK_SHOULDER  = 3'd0;
  localparam logic [IDX_W-1:0] IDX_SHOULDER_ELBOW = 3'd1;
  localparam logic [IDX_W-1:0] IDX_ELBOW_WRIST    = 3'd2;
  localparam logic [IDX_W-1:0] IDX_HIP_THIGH      = 3'd3;
  localparam logic [IDX_W-1:0] IDX_THIGH_KNEE     = 3'd4;
  localparam logic [IDX_W-1:0] IDX_KNEE_ANKLE     = 3'd5;
  localparam logic [IDX_W-1:0] IDX_HIP_CHEST      = 3'd6;
  localparam logic [IDX_W-1:0] IDX_CHEST_NECK     = 3'd7;

  localparam len_t LEN_RESET [NUM_LEN] = '{
    16'd3277, 16'd4424, 16'd4424, 16'd2458, 16'd9011, 16'd7373, 16'd5407, 16'd3113
  };

  typedef struct packed {
    logic [CHAIN_W-1:0]        chain;
    logic                      ok;
    logic signed [COORD_W-1:0] root_x;
    logic signed [COORD_W-1:0] root_y;
    logic signed [COORD_W-1:0] root_z;
  } side_t;

endpackage

[hdl/skeleton_chain_forward_kinematics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_chain_forward_kinematics
// End-point position of a three-link skeleton chain from three quaternions,
// configured bone lengths and a root position.
// ----------------------------------------------------------------------------
// A transfer is accepted whenever start is high; busy is always low, so one
// item can enter every cycle. Each result appears at the end of the pipeline,
// in order, for one cycle with done_o high, and cannot be held off. The six
// stages are: input decode, quaternion products, rotated directions, length
// multiplies, term sum with rounding, and root add with saturation. A chain
// number above four gives a zero position with result_valid_o low.
module skeleton_chain_forward_kinematics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic                          cfg_we_i,
  input  logic [scfk_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [scfk_pkg::LEN_W-1:0]    cfg_data_i,
  input  logic [scfk_pkg::CHAIN_W-1:0]  chain_select_i,
  input  logic [scfk_pkg::QUAT_W-1:0]   quat_root_i,
  input  logic [scfk_pkg::QUAT_W-1:0]   quat_link_i,
  input  logic [scfk_pkg::QUAT_W-1:0]   quat_end_i,
  input  logic signed [scfk_pkg::COORD_W-1:0] root_x_i,
  input  logic signed [scfk_pkg::COORD_W-1:0] root_y_i,
  input  logic signed [scfk_pkg::COORD_W-1:0] root_z_i,
  output logic [scfk_pkg::CHAIN_W-1:0]  chain_echo_o,
  output logic signed [scfk_pkg::COORD_W-1:0] end_x_o,
  output logic signed [scfk_pkg::COORD_W-1:0] end_y_o,
  output logic signed [scfk_pkg::COORD_W-1:0] end_z_o,
  output logic                          result_valid_o
);
  import scfk_pkg::*;

  localparam int NL = 3;
  localparam int RS = 2 * FRAC_BITS;
  localparam int POS_W = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RS - 1);
  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(1 << (COORD_W - 1));

  len_t len_q [NUM_LEN];

  axis_e axis_d [NL];
  len_t  lsel_d [NL];
  logic  ok_d;

  axis_e axis_q1 [NL];
  len_t  len_q1 [NL], len_q2 [NL], len_q3 [NL];
  logic [QUAT_W-1:0] quat_q1 [NL];
  side_t side_q1, side_q2, side_q3, side_q4, side_q5;
  logic  v1_q, v2_q, v3_q, v4_q, v5_q;

  dir_t dx [NL], dy [NL], dz [NL];
  logic signed [LEN_W:0] lens [NL];
  logic signed [TERM_W-1:0] tx_q [NL], ty_q [NL], tz_q [NL];
  logic signed [SUM_W-1:0] sx_q, sy_q, sz_q;

  logic signed [POS_W-1:0] px, py, pz;
  logic signed [COORD_W-1:0] end_x_q, end_y_q, end_z_q;
  logic [CHAIN_W-1:0] chain_q;
  logic result_valid_q, done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEN; i++) begin
        len_q[i] <= LEN_RESET[i];
      end
    end else if (cfg_we_i) begin
      len_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    ok_d = 1'b1;
    case (chain_select_i)
      CHAIN_LEFT_WRIST, CHAIN_RIGHT_WRIST: begin
        axis_d[0] = (chain_select_i == CHAIN_LEFT_WRIST) ? AXIS_PX : AXIS_NX;
        axis_d[1] = axis_d[0];
        axis_d[2] = axis_d[0];
        lsel_d[0] = len_q[IDX_NECK_SHOULDER];
        lsel_d[1] = len_q[IDX_SHOULDER_ELBOW];
        lsel_d[2] = len_q[IDX_ELBOW_WRIST];
      end
      CHAIN_LEFT_ANKLE, CHAIN_RIGHT_ANKLE: begin
        axis_d[0] = (chain_select_i == CHAIN_LEFT_ANKLE) ? AXIS_PX : AXIS_NX;
        axis_d[1] = AXIS_NY;
        axis_d[2] = AXIS_NY;
        lsel_d[0] = len_q[IDX_HIP_THIGH];
        lsel_d[1] = len_q[IDX_THIGH_KNEE];
        lsel_d[2] = len_q[IDX_KNEE_ANKLE];
      end
      CHAIN_NECK: begin
        axis_d[0] = AXIS_PY;
        axis_d[1] = AXIS_PY;
        axis_d[2] = AXIS_PY;
        lsel_d[0] = len_q[IDX_HIP_CHEST];
        lsel_d[1] = '0;
        lsel_d[2] = len_q[IDX_CHEST_NECK];
      end
      default: begin
        ok_d = 1'b0;
        axis_d[0] = AXIS_PX;
        axis_d[1] = AXIS_PX;
        axis_d[2] = AXIS_PX;
        lsel_d[0] = '0;
        lsel_d[1] = '0;
        lsel_d[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q1    <= axis_d;
    len_q1     <= lsel_d;
    len_q2     <= len_q1;
    len_q3     <= len_q2;
    quat_q1[0] <= quat_root_i;
    quat_q1[1] <= quat_link_i;
    quat_q1[2] <= quat_end_i;
    side_q1    <= '{chain: chain_select_i, ok: ok_d,
                    root_x: root_x_i, root_y: root_y_i, root_z: root_z_i};
    side_q2    <= side_q1;
    side_q3    <= side_q2;
    side_q4    <= side_q3;
    side_q5    <= side_q4;
  end

  for (genvar l = 0; l < NL; l++) begin : g_link
    scfk_rotate u_rotate (
      .clk_i  (clk_i),
      .axis_i (axis_q1[l]),
      .quat_i (quat_q1[l]),
      .dir_x_o(dx[l]),
      .dir_y_o(dy[l]),
      .dir_z_o(dz[l])
    );

    assign lens[l] = $signed({1'b0, len_q3[l]});

    always_ff @(posedge clk_i) begin
      tx_q[l] <= TERM_W'(lens[l]) * TERM_W'(dx[l]);
      ty_q[l] <= TERM_W'(lens[l]) * TERM_W'(dy[l]);
      tz_q[l] <= TERM_W'(lens[l]) * TERM_W'(dz[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= SUM_W'(tx_q[0]) + SUM_W'(tx_q[1]) + SUM_W'(tx_q[2]) + ROUND_HALF;
    sy_q <= SUM_W'(ty_q[0]) + SUM_W'(ty_q[1]) + SUM_W'(ty_q[2]) + ROUND_HALF;
    sz_q <= SUM_W'(tz_q[0]) + SUM_W'(tz_q[1]) + SUM_W'(tz_q[2]) + ROUND_HALF;
  end

  assign px = POS_W'(sx_q >>> RS) + POS_W'(side_q5.root_x);
  assign py = POS_W'(sy_q >>> RS) + POS_W'(side_q5.root_y);
  assign pz = POS_W'(sz_q >>> RS) + POS_W'(side_q5.root_z);

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [POS_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[COORD_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    chain_q        <= side_q5.chain;
    result_valid_q <= side_q5.ok;
    end_x_q        <= side_q5.ok ? sat(px) : '0;
    end_y_q        <= side_q5.ok ? sat(py) : '0;
    end_z_q        <= side_q5.ok ? sat(pz) : '0;
  end

  assign done_o         = done_q;
  assign chain_echo_o   = chain_q;
  assign result_valid_o = result_valid_q;
  assign end_x_o        = end_x_q;
  assign end_y_o        = end_y_q;
  assign end_z_o        = end_z_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 6))
    else $error("result without a matching start");

  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("start did not produce a result");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_valid_o) |-> (end_x_o == '0 && end_y_o == '0 && end_z_o == '0))
    else $error("invalid chain gave a nonzero position");

  a_valid_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_valid_o) |-> (chain_echo_o <= CHAIN_NECK))
    else $error("valid result for an unknown chain");

endmodule

[hdl/scfk_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfk_rotate
// Two-stage rotation of a signed axis direction by an unnormalized quaternion
// (q v q*): registered component products, then registered direction sums.
// ----------------------------------------------------------------------------
module scfk_rotate (
  input  logic                     clk_i,
  input  scfk_pkg::axis_e          axis_i,
  input  logic [scfk_pkg::QUAT_W-1:0] quat_i,
  output scfk_pkg::dir_t           dir_x_o,
  output scfk_pkg::dir_t           dir_y_o,
  output scfk_pkg::dir_t           dir_z_o
);
  import scfk_pkg::*;

  logic signed [COMP_W-1:0] w, x, y, z;
  logic signed [PROD_W-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  axis_e axis_q;
  dir_t  d0, d1, d2;
  dir_t  dir_x_q, dir_y_q, dir_z_q;
  logic  neg;

  assign w = $signed(quat_i[4*COMP_W-1:3*COMP_W]);
  assign x = $signed(quat_i[3*COMP_W-1:2*COMP_W]);
  assign y = $signed(quat_i[2*COMP_W-1:COMP_W]);
  assign z = $signed(quat_i[COMP_W-1:0]);

  always_ff @(posedge clk_i) begin
    ww_q   <= PROD_W'(w) * PROD_W'(w);
    xx_q   <= PROD_W'(x) * PROD_W'(x);
    yy_q   <= PROD_W'(y) * PROD_W'(y);
    zz_q   <= PROD_W'(z) * PROD_W'(z);
    xy_q   <= PROD_W'(x) * PROD_W'(y);
    wz_q   <= PROD_W'(w) * PROD_W'(z);
    xz_q   <= PROD_W'(x) * PROD_W'(z);
    wy_q   <= PROD_W'(w) * PROD_W'(y);
    yz_q   <= PROD_W'(y) * PROD_W'(z);
    wx_q   <= PROD_W'(w) * PROD_W'(x);
    axis_q <= axis_i;
  end

  always_comb begin
    neg = (axis_q == AXIS_NX) || (axis_q == AXIS_NY);
    case (axis_q)
      AXIS_PX, AXIS_NX: begin
        d0 = DIR_W'(ww_q) + DIR_W'(xx_q) - DIR_W'(yy_q) - DIR_W'(zz_q);
        d1 = (DIR_W'(xy_q) + DIR_W'(wz_q)) <<< 1;
        d2 = (DIR_W'(xz_q) - DIR_W'(wy_q)) <<< 1;
      end
      default: begin
        d0 = (DIR_W'(xy_q) - DIR_W'(wz_q)) <<< 1;
        d1 = DIR_W'(ww_q) - DIR_W'(xx_q) + DIR_W'(yy_q) - DIR_W'(zz_q);
        d2 = (DIR_W'(yz_q) + DIR_W'(wx_q)) <<< 1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dir_x_q <= neg ? -d0 : d0;
    dir_y_q <= neg ? -d1 : d1;
    dir_z_q <= neg ? -d2 : d2;
  end

  assign dir_x_o = dir_x_q;
  assign dir_y_o = dir_y_q;
  assign dir_z_o = dir_z_q;

endmodule
